// File: sv/sacf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// sacf_pkg: command, shift kind, carry and condition codes of the shifter and flag unit
// plus the flag bit positions and a 32-bit rotate helper; no dependencies

package sacf_pkg;

    // command codes
    localparam logic [2:0] CMD_SHIFT      = 3'd0;
    localparam logic [2:0] CMD_IMM_ROTATE = 3'd1;
    localparam logic [2:0] CMD_LOGIC_FLAG = 3'd2;
    localparam logic [2:0] CMD_ARITH_FLAG = 3'd3;
    localparam logic [2:0] CMD_COND_TEST  = 3'd4;

    // shift kinds
    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // carry codes, both for the shifter carry out and the logical update
    localparam logic [1:0] CARRY_CLEAR     = 2'd0;
    localparam logic [1:0] CARRY_SET       = 2'd1;
    localparam logic [1:0] CARRY_UNCHANGED = 2'd2;
    localparam logic [1:0] CARRY_RESERVED  = 2'd3;

    // condition field codes
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;

    // flag positions in the packed flag word
    localparam int FLAG_V_POS = 0;
    localparam int FLAG_C_POS = 1;
    localparam int FLAG_Z_POS = 2;
    localparam int FLAG_N_POS = 3;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef logic [3:0] flags_t;

    // one accepted input word
    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  shift_kind;
        logic [7:0]  amount;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [31:0] result_value;
        logic        is_addition;
        logic [1:0]  carry_code;
        logic [3:0]  condition_code;
    } item_t;

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] dbl;
        dbl = {v, v} >> r;
        return dbl[31:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/shifter_and_condition_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// shifter_and_condition_flags: barrel shifter, N Z C V flag register and condition test
// depends on sacf_pkg
//
//  channel | ports                                  | dir | meaning
//  --------+----------------------------------------+-----+--------------------------------
//  s_      | s_valid s_ready s_command ... s_cond.. | in  | one command word per handshake
//  m_      | m_valid m_ready m_shifted_value ...    | out | one result word per command
//
// one word per cycle sustained while m_ready is high; from s_ handshake to m_valid a word passes
// the input register, then the shift/flag logic feeding the result register
// the flag register updates when a word moves from the input to the result register,
// so RRX and the condition test always see the flags left by the previous word
// aresetn (synchronous, active low) clears both valid bits and the flags
// a stalled m_ side holds the result; the input register still takes one more word

module shifter_and_condition_flags
    import sacf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [1:0]  s_shift_kind,
    input  wire logic [7:0]  s_amount,
    input  wire logic [31:0] s_first_value,
    input  wire logic [31:0] s_second_value,
    input  wire logic [31:0] s_result_value,
    input  wire logic        s_is_addition,
    input  wire logic [1:0]  s_carry_code,
    input  wire logic [3:0]  s_condition_code,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_shifted_value,
    output logic [1:0]       m_carry_result,
    output logic             m_condition_passed,
    output logic [3:0]       m_flags_now
);

    // input register
    item_t       in_reg;
    logic        in_valid_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [1:0]  carry_reg;
    logic        passed_reg;
    flags_t      flags_out_reg;

    // architectural flags
    flags_t      flags_reg;

    // compute results
    logic [31:0] value_next;
    logic [1:0]  carry_next;
    logic        passed_next;
    flags_t      flags_next;

    logic        advance;

    // word moves from input to result register when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // shift datapath
    logic        amt_zero;
    logic        amt_big;      // 32 or more
    logic        amt_is_32;
    logic [4:0]  amt_lo;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [31:0] ror_val;
    logic [31:0] imm_val;
    logic [4:0]  imm_rot;
    logic        sign_a;
    logic        sh_carry;
    logic [32:0] add_sum;
    logic        sa, sb, sr;
    logic        n_f, z_f, c_f, v_f;

    always_comb begin
        amt_lo    = in_reg.amount[4:0];
        amt_zero  = (in_reg.amount == 8'd0);
        amt_big   = (in_reg.amount[7:5] != 3'd0);
        amt_is_32 = (in_reg.amount == 8'd32);
        sign_a    = in_reg.first_value[31];

        // extra bit catches the last bit shifted out
        lsl_wide = {1'b0, in_reg.first_value} << amt_lo;
        lsr_wide = {in_reg.first_value, 1'b0} >> amt_lo;
        asr_wide = 33'($signed({in_reg.first_value, 1'b0}) >>> amt_lo);
        ror_val  = ror32(in_reg.first_value, amt_lo);
        imm_rot  = {in_reg.amount[3:0], 1'b0};
        imm_val  = ror32(in_reg.first_value, imm_rot);

        add_sum = {1'b0, in_reg.first_value} + {1'b0, in_reg.second_value};
        sa = in_reg.first_value[31];
        sb = in_reg.second_value[31];
        sr = in_reg.result_value[31];

        n_f = flags_reg[FLAG_N_POS];
        z_f = flags_reg[FLAG_Z_POS];
        c_f = flags_reg[FLAG_C_POS];
        v_f = flags_reg[FLAG_V_POS];

        value_next  = 32'd0;
        carry_next  = CARRY_UNCHANGED;
        passed_next = 1'b0;
        flags_next  = flags_reg;
        sh_carry    = 1'b0;

        case (in_reg.command)
            CMD_SHIFT: begin
                case (in_reg.shift_kind)
                    SHIFT_LSL: begin
                        if (amt_zero) begin
                            value_next = in_reg.first_value;
                        end else if (!amt_big) begin
                            value_next = lsl_wide[31:0];
                            sh_carry   = lsl_wide[32];
                            carry_next = {1'b0, sh_carry};
                        end else begin
                            // exactly 32 moves bit 0 into carry, beyond gives 0
                            sh_carry   = amt_is_32 && in_reg.first_value[0];
                            carry_next = {1'b0, sh_carry};
                        end
                    end
                    SHIFT_LSR: begin
                        if (!amt_zero && !amt_big) begin
                            value_next = lsr_wide[32:1];
                            sh_carry   = lsr_wide[0];
                        end else begin
                            // zero acts as 32
                            sh_carry = (amt_zero || amt_is_32) && sign_a;
                        end
                        carry_next = {1'b0, sh_carry};
                    end
                    SHIFT_ASR: begin
                        if (amt_zero || amt_big) begin
                            value_next = sign_a ? ALL_ONES : 32'd0;
                            sh_carry   = sign_a;
                        end else begin
                            value_next = asr_wide[32:1];
                            sh_carry   = asr_wide[0];
                        end
                        carry_next = {1'b0, sh_carry};
                    end
                    default: begin
                        if (amt_zero) begin
                            // rrx: stored carry enters at the top
                            value_next = {c_f, in_reg.first_value[31:1]};
                            sh_carry   = in_reg.first_value[0];
                        end else begin
                            value_next = ror_val;
                            sh_carry   = ror_val[31];
                        end
                        carry_next = {1'b0, sh_carry};
                    end
                endcase
            end
            CMD_IMM_ROTATE: begin
                if (in_reg.amount[3:0] == 4'd0) begin
                    value_next = in_reg.first_value;
                end else begin
                    value_next = imm_val;
                    carry_next = {1'b0, imm_val[31]};
                end
            end
            CMD_LOGIC_FLAG: begin
                flags_next[FLAG_N_POS] = in_reg.result_value[31];
                flags_next[FLAG_Z_POS] = (in_reg.result_value == 32'd0);
                case (in_reg.carry_code)
                    CARRY_CLEAR: flags_next[FLAG_C_POS] = 1'b0;
                    CARRY_SET:   flags_next[FLAG_C_POS] = 1'b1;
                    default:     flags_next[FLAG_C_POS] = c_f;
                endcase
            end
            CMD_ARITH_FLAG: begin
                flags_next[FLAG_N_POS] = in_reg.result_value[31];
                flags_next[FLAG_Z_POS] = (in_reg.result_value == 32'd0);
                if (in_reg.is_addition) begin
                    flags_next[FLAG_C_POS] = add_sum[32];
                    flags_next[FLAG_V_POS] = (sa == sb) && (sr != sa);
                end else begin
                    // no borrow
                    flags_next[FLAG_C_POS] = (in_reg.second_value <= in_reg.first_value);
                    flags_next[FLAG_V_POS] = (sa != sb) && (sr == sb);
                end
            end
            CMD_COND_TEST: begin
                case (in_reg.condition_code)
                    COND_EQ: passed_next = z_f;
                    COND_NE: passed_next = !z_f;
                    COND_CS: passed_next = c_f;
                    COND_CC: passed_next = !c_f;
                    COND_MI: passed_next = n_f;
                    COND_PL: passed_next = !n_f;
                    COND_VS: passed_next = v_f;
                    COND_VC: passed_next = !v_f;
                    COND_HI: passed_next = c_f && !z_f;
                    COND_LS: passed_next = !c_f || z_f;
                    COND_GE: passed_next = (n_f == v_f);
                    COND_LT: passed_next = (n_f != v_f);
                    COND_GT: passed_next = !z_f && (n_f == v_f);
                    COND_LE: passed_next = z_f || (n_f != v_f);
                    default: passed_next = 1'b1;   // always, and never treated as always
                endcase
            end
            default: begin
                // undefined commands: no operation
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.command        <= s_command;
            in_reg.shift_kind     <= s_shift_kind;
            in_reg.amount         <= s_amount;
            in_reg.first_value    <= s_first_value;
            in_reg.second_value   <= s_second_value;
            in_reg.result_value   <= s_result_value;
            in_reg.is_addition    <= s_is_addition;
            in_reg.carry_code     <= s_carry_code;
            in_reg.condition_code <= s_condition_code;
        end
        if (advance) begin
            value_reg     <= value_next;
            carry_reg     <= carry_next;
            passed_reg    <= passed_next;
            flags_out_reg <= flags_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_shifted_value    = value_reg;
    assign m_carry_result     = carry_reg;
    assign m_condition_passed = passed_reg;
    assign m_flags_now        = flags_out_reg;

    // while m_valid is high, the reported flags equal the live flag register
    a_flags_match : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_flags_now == flags_reg))
        else $error("reported flags differ from flag register");

    // input only backs up when both stages are full and the output is stalled
    a_ready_low : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // flags never move unless a word goes through the logic
    a_flags_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> (flags_reg == $past(flags_reg)))
        else $error("flags changed without a word");

    // a passed condition comes only from a condition test, which has no shift result
    a_pass_alone : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_condition_passed) |->
            (m_shifted_value == 32'd0 && m_carry_result == CARRY_UNCHANGED))
        else $error("condition pass together with shift result");

    // carry code three is never produced
    a_carry_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_carry_result != CARRY_RESERVED))
        else $error("reserved carry code on output");

endmodule

`default_nettype wire
